@@ hdl/wfpa_pkg.sv @@
// shared types, constants and the reset layout of the worst fit allocator
package wfpa_pkg;

   // sizes of the address space and of the range table
   localparam int MEM_SIZE    = 1024;
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = 10;
   localparam int SIZE_W      = 11;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int INIT_COUNT  = 4;

   // result status codes
   typedef enum logic [1:0] {
      ST_GRANT = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2,
      ST_BAD   = 2'd3
   } wfpa_status_type;

   // pointer operations
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_CLR,
      PTR_INC,
      PTR_DEC,
      PTR_TOP
   } wfpa_ptr_op_type;

   // one table entry
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] last;
      logic              taken;
   } wfpa_entry_type;

   // controller to datapath
   typedef struct packed {
      logic            init_wr;
      logic            load_req;
      logic            scan_rd;
      logic            shift_rd;
      logic            split_wr;
      logic            best_wr;
      logic            set_result;
      wfpa_ptr_op_type ptr_op;
      wfpa_status_type code;
   } wfpa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic size_zero;
      logic init_end;
      logic scan_end;
      logic shift_end;
      logic found;
      logic left_nz;
      logic full;
      logic need_shift;
      logic rsp_free;
   } wfpa_sts_type;

   // reset layout of the first table entries
   function automatic wfpa_entry_type init_entry(input logic [IDX_W-1:0] idx);
      wfpa_entry_type e;
      e = '0;
      case (idx)
         IDX_W'(0): begin
            e.start = ADDR_W'(0);
            e.last  = ADDR_W'(199);
            e.taken = 1'b1;
         end
         IDX_W'(1): begin
            e.start = ADDR_W'(200);
            e.last  = ADDR_W'(499);
         end
         IDX_W'(2): begin
            e.start = ADDR_W'(500);
            e.last  = ADDR_W'(699);
         end
         IDX_W'(3): begin
            e.start = ADDR_W'(700);
            e.last  = ADDR_W'(MEM_SIZE - 1);
         end
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

@@ hdl/wfpa_datapath.sv @@
// range table memory, worst fit scan registers, insert shifter and result register
module wfpa_datapath import wfpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  wfpa_cmd_type        cmd,
   output wfpa_sts_type        sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [ADDR_W-1:0]   rsp_grant_start,
   output logic [ADDR_W-1:0]   rsp_grant_end
);

   wfpa_entry_type        entry_mem_ff [TABLE_DEPTH];
   wfpa_entry_type        rdata_ff;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [IDX_W-1:0]      idx_ff;
   logic                  eval_ff;
   logic                  shv_ff;
   logic [IDX_W-1:0]      shwa_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [SIZE_W-1:0]     best_left_ff;
   logic [ADDR_W-1:0]     best_start_ff;
   logic [ADDR_W-1:0]     best_last_ff;
   logic                  rsp_valid_ff;
   wfpa_status_type       rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_start_ff;
   logic [ADDR_W-1:0]     rsp_end_ff;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   wfpa_entry_type        wr_data;
   logic [SIZE_W-1:0]     len;
   logic [SIZE_W-1:0]     left;
   logic                  better;
   logic [SIZE_W-1:0]     split_start_w;
   logic [SIZE_W-1:0]     grant_last_w;

   // address arithmetic on the chosen range
   assign split_start_w = SIZE_W'(best_start_ff) + size_ff;
   assign grant_last_w  = SIZE_W'(best_start_ff) + size_ff - SIZE_W'(1);

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rdata_ff;
      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         wr_data = init_entry(ptr_ff);
      end else if (shv_ff) begin
         wr_en   = 1'b1;
         wr_addr = shwa_ff;
         wr_data = rdata_ff;
      end else if (cmd.split_wr) begin
         wr_en         = 1'b1;
         wr_addr       = best_idx_ff + IDX_W'(1);
         wr_data.start = split_start_w[ADDR_W-1:0];
         wr_data.last  = best_last_ff;
         wr_data.taken = 1'b0;
      end else if (cmd.best_wr) begin
         wr_en         = 1'b1;
         wr_addr       = best_idx_ff;
         wr_data.start = best_start_ff;
         wr_data.last  = grant_last_w[ADDR_W-1:0];
         wr_data.taken = 1'b1;
      end
   end

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= entry_mem_ff[ptr_ff];
   end

   // leftover of the entry just read
   always_comb begin
      if (rdata_ff.last >= rdata_ff.start) begin
         len = SIZE_W'(rdata_ff.last) - SIZE_W'(rdata_ff.start) + SIZE_W'(1);
      end else begin
         len = '0;
      end
      left   = len - size_ff;
      better = !rdata_ff.taken && (len >= size_ff) && (!found_ff || (left > best_left_ff));
   end

   // table pointer
   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_CLR:  ptr_in = '0;
         PTR_INC:  ptr_in = ptr_ff + IDX_W'(1);
         PTR_DEC:  ptr_in = ptr_ff - IDX_W'(1);
         PTR_TOP:  ptr_in = IDX_W'(count_ff - CNT_W'(1));
         default:  ptr_in = ptr_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         eval_ff      <= 1'b0;
         shv_ff       <= 1'b0;
         count_ff     <= CNT_W'(INIT_COUNT);
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         eval_ff <= cmd.scan_rd;
         shv_ff  <= cmd.shift_rd;
         if (cmd.load_req) begin
            found_ff <= 1'b0;
         end else if (eval_ff && better) begin
            found_ff <= 1'b1;
         end
         if (cmd.best_wr && (best_left_ff != '0)) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.set_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= ptr_ff;
      shwa_ff <= ptr_ff + IDX_W'(1);
      if (cmd.load_req) begin
         size_ff <= req_request_size;
      end
      if (eval_ff && better) begin
         best_idx_ff   <= idx_ff;
         best_left_ff  <= left;
         best_start_ff <= rdata_ff.start;
         best_last_ff  <= rdata_ff.last;
      end
      if (cmd.set_result) begin
         rsp_status_ff <= cmd.code;
         if (cmd.code == ST_GRANT) begin
            rsp_start_ff <= best_start_ff;
            rsp_end_ff   <= grant_last_w[ADDR_W-1:0];
         end else begin
            rsp_start_ff <= '0;
            rsp_end_ff   <= '0;
         end
      end
   end

   // status to the controller
   always_comb begin
      sts.size_zero  = (req_request_size == '0);
      sts.init_end   = (ptr_ff == IDX_W'(INIT_COUNT - 1));
      sts.scan_end   = (CNT_W'(ptr_ff) == (count_ff - CNT_W'(1)));
      sts.shift_end  = (ptr_ff == (best_idx_ff + IDX_W'(1)));
      sts.found      = found_ff;
      sts.left_nz    = (best_left_ff != '0);
      sts.full       = (count_ff == CNT_W'(TABLE_DEPTH));
      sts.need_shift = ((CNT_W'(best_idx_ff) + CNT_W'(1)) != count_ff);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // result channel
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_grant_start = rsp_start_ff;
   assign rsp_grant_end   = rsp_end_ff;

endmodule

@@ hdl/wfpa_ctrl.sv @@
// sequencer for table load, worst fit scan, insert shift and result hand off
module wfpa_ctrl import wfpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output wfpa_cmd_type  cmd,
   input  wfpa_sts_type  sts
);

   typedef enum logic [3:0] {
      INIT,
      IDLE,
      SCAN,
      SCAN_WAIT,
      DECIDE,
      SHIFT,
      DRAIN,
      SPLIT,
      BEST,
      FINISH
   } state_type;

   state_type        state_ff, state_in;
   wfpa_status_type  code_ff, code_in;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.ptr_op     = PTR_HOLD;
      cmd.code       = code_ff;
      case (state_ff)
         INIT: begin
            cmd.init_wr = 1'b1;
            cmd.ptr_op  = PTR_INC;
            if (sts.init_end) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.ptr_op   = PTR_CLR;
               if (sts.size_zero) begin
                  code_in  = ST_BAD;
                  state_in = FINISH;
               end else begin
                  state_in = SCAN;
               end
            end
         end
         SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.ptr_op  = PTR_INC;
            if (sts.scan_end) begin
               state_in = SCAN_WAIT;
            end
         end
         SCAN_WAIT: begin
            state_in = DECIDE;
         end
         DECIDE: begin
            if (!sts.found) begin
               code_in  = ST_NOFIT;
               state_in = FINISH;
            end else if (!sts.left_nz) begin
               state_in = BEST;
            end else if (sts.full) begin
               code_in  = ST_FULL;
               state_in = FINISH;
            end else if (sts.need_shift) begin
               cmd.ptr_op = PTR_TOP;
               state_in   = SHIFT;
            end else begin
               state_in = SPLIT;
            end
         end
         SHIFT: begin
            cmd.shift_rd = 1'b1;
            cmd.ptr_op   = PTR_DEC;
            if (sts.shift_end) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = SPLIT;
         end
         SPLIT: begin
            cmd.split_wr = 1'b1;
            state_in     = BEST;
         end
         BEST: begin
            cmd.best_wr = 1'b1;
            code_in     = ST_GRANT;
            state_in    = FINISH;
         end
         FINISH: begin
            if (sts.rsp_free) begin
               cmd.set_result = 1'b1;
               state_in       = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and status code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= INIT;
         code_ff  <= ST_NOFIT;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ hdl/worst_fit_partition_allocator_top.sv @@
// top level of the worst fit partition allocator
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_request_size
//   rsp_      out        rsp_valid / rsp_ready  rsp_status, rsp_grant_start, rsp_grant_end
//
// one request at a time: the scan reads each of the n live table entries; an exact fit
// then marks the chosen entry taken, a split also writes the remainder behind it, and
// a split of any but the last entry first shifts the table tail up one place
// after reset the first four table entries are loaded with req_ready low
// a finished result sits in the output register; the next request is taken meanwhile,
// and only a second result waits for rsp_ready
module worst_fit_partition_allocator_top import wfpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SIZE_W-1:0]   req_request_size,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [ADDR_W-1:0]   rsp_grant_start,
   output logic [ADDR_W-1:0]   rsp_grant_end
);

   wfpa_cmd_type cmd;
   wfpa_sts_type sts;

   // sequencer
   wfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // table and result datapath
   wfpa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_request_size (req_request_size),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_grant_start  (rsp_grant_start),
      .rsp_grant_end    (rsp_grant_end)
   );

endmodule
